// ----- rtl/core/mce_pkg.sv -----
// Package for the multiset count engine.
// Holds default sizes, the request codes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package mce_pkg;

    localparam int DIM_DEF         = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int VALUE_W         = 24;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_REMOVE    = 4'd1,
        OP_COUNT     = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_COPY      = 4'd4,
        OP_UNION     = 4'd5,
        OP_INTERSECT = 4'd6,
        OP_DIFF      = 4'd7,
        OP_SUBSET    = 4'd8,
        OP_EQUAL     = 4'd9,
        OP_EMPTY     = 4'd10,
        OP_CARD      = 4'd11,
        OP_DISTINCT  = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ELEM,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/core/mce_ram.sv -----
// Single-port-write, single-port-read memory with a registered read.
// Holds one row per element: the counts of both bags side by side.
// Depends on nothing.
`timescale 1ns / 1ps

module mce_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/multiset_count_engine.sv -----
// Top level of the multiset count engine: controller, entry datapath and result register.
// Depends on mce_pkg and mce_ram.
//
// Channel  Dir  Handshake               Payload
// s        in   i_s_tvalid/o_s_tready   tuser: req_type, bag_sel; tdata: element
// m        out  o_m_tvalid/i_m_tready   tdata: value, flag, saturated
//
// Add, remove, count and unknown requests pass through the element and finish steps before the result is registered.
// Whole-bag requests read and write one memory row per cycle, then drain and finish.
// After reset a clearing pass writes all DIM rows with o_s_tready low.
// One request is in flight at a time; a stalled result holds the controller in its last step.
`timescale 1ns / 1ps

module multiset_count_engine
    import mce_pkg::*;
#(
    parameter int DIM         = DIM_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] element
    input  logic [4:0]  i_s_tuser,   // [3:0] req_type, [4] bag_sel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [23:0] value, [24] flag, [25] saturated
);

    localparam int AW = $clog2(DIM);
    localparam int CW = COUNT_WIDTH;
    localparam int RW = 2 * COUNT_WIDTH;
    localparam logic [AW-1:0] LAST_IDX = AW'(DIM - 1);
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};

    t_state r_state, n_state;
    t_op    r_op;
    logic   r_sel;
    logic [7:0]    r_el;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_pidx;
    logic          r_pv;
    logic [VALUE_W-1:0] r_acc;
    logic   r_flag;
    logic   r_sat;
    logic   r_ovalid;
    logic [31:0] r_odata;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic s_fire, out_free;
    t_op  in_op;
    logic [31:0]   in_el32, r_el32;
    logic [AW-1:0] in_addr, r_addr;
    logic          r_in_range;
    logic [CW-1:0] cur_t, cur_o, elem_t, walk_t;
    logic [CW:0]   usum;
    logic          elem_we, walk_we, walk_sat, walk_bad, is_walk_op;
    logic [31:0]   addend;
    logic [32:0]   acc_sum;
    logic [VALUE_W-1:0] acc_next;
    logic [RW-1:0] new_row;
    logic [31:0]   t32;
    logic [VALUE_W-1:0] fin_value;
    logic          fin_flag;

    mce_ram #(
        .DEPTH (DIM),
        .WIDTH (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    assign in_op      = t_op'(i_s_tuser[3:0]);
    assign in_el32    = 32'(i_s_tdata);
    assign in_addr    = in_el32[AW-1:0];
    assign r_el32     = 32'(r_el);
    assign r_addr     = r_el32[AW-1:0];
    assign r_in_range = r_el32 < 32'(DIM);

    assign cur_t = r_sel ? ram_rdata[RW-1:CW] : ram_rdata[CW-1:0];
    assign cur_o = r_sel ? ram_rdata[CW-1:0]  : ram_rdata[RW-1:CW];
    assign usum  = {1'b0, cur_t} + {1'b0, cur_o};
    assign t32   = 32'(cur_t);

    always_comb begin
        unique case (r_op)
            OP_CLEAR, OP_COPY, OP_UNION, OP_INTERSECT, OP_DIFF,
            OP_SUBSET, OP_EQUAL, OP_EMPTY, OP_CARD, OP_DISTINCT: is_walk_op = 1'b1;
            default: is_walk_op = 1'b0;
        endcase
    end

    // Per-entry update of the target count for element requests.
    always_comb begin
        elem_t  = cur_t;
        elem_we = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                if (r_in_range && cur_t != CNT_MAX) begin
                    elem_t  = cur_t + CW'(1);
                    elem_we = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_in_range && cur_t != '0) begin
                    elem_t  = cur_t - CW'(1);
                    elem_we = 1'b1;
                end
            end
            default: begin
                elem_t  = cur_t;
                elem_we = 1'b0;
            end
        endcase
    end

    // Per-entry update and test for whole-bag requests.
    always_comb begin
        walk_t   = cur_t;
        walk_we  = 1'b0;
        walk_sat = 1'b0;
        walk_bad = 1'b0;
        addend   = '0;
        unique case (r_op)
            OP_CLEAR: begin
                walk_t  = '0;
                walk_we = 1'b1;
            end
            OP_COPY: begin
                walk_t  = cur_o;
                walk_we = 1'b1;
            end
            OP_UNION: begin
                walk_we  = 1'b1;
                walk_sat = usum[CW];
                walk_t   = usum[CW] ? CNT_MAX : usum[CW-1:0];
            end
            OP_INTERSECT: begin
                walk_we = 1'b1;
                walk_t  = (cur_t > cur_o) ? cur_o : cur_t;
            end
            OP_DIFF: begin
                walk_we = 1'b1;
                walk_t  = (cur_t < cur_o) ? '0 : cur_t - cur_o;
            end
            OP_SUBSET:   walk_bad = cur_t > cur_o;
            OP_EQUAL:    walk_bad = cur_t != cur_o;
            OP_EMPTY:    walk_bad = cur_t != '0;
            OP_CARD:     addend   = t32;
            OP_DISTINCT: addend   = 32'(cur_t != '0);
            default: begin
                walk_t = cur_t;
            end
        endcase
    end

    assign acc_sum  = 33'(r_acc) + 33'(addend);
    assign acc_next = (acc_sum > 33'(VALUE_MAX)) ? VALUE_MAX : acc_sum[VALUE_W-1:0];

    always_comb begin
        unique case (r_state)
            S_ELEM:  new_row = r_sel ? {elem_t, ram_rdata[CW-1:0]}
                                     : {ram_rdata[RW-1:CW], elem_t};
            default: new_row = r_sel ? {walk_t, ram_rdata[CW-1:0]}
                                     : {ram_rdata[RW-1:CW], walk_t};
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    unique case (in_op)
                        OP_ADD, OP_REMOVE, OP_COUNT: n_state = S_ELEM;
                        OP_CLEAR, OP_COPY, OP_UNION, OP_INTERSECT, OP_DIFF,
                        OP_SUBSET, OP_EQUAL, OP_EMPTY, OP_CARD,
                        OP_DISTINCT: n_state = S_WALK;
                        default: n_state = S_ELEM;
                    endcase
                end
            end
            S_ELEM:  n_state = S_FINISH;
            S_WALK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Memory controls.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        ram_wdata = new_row;
        ram_raddr = r_idx;
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
            end
            S_IDLE:  ram_raddr = in_addr;
            S_ELEM: begin
                ram_we    = elem_we;
                ram_waddr = r_addr;
            end
            default: begin
                ram_we    = r_pv && walk_we;
                ram_waddr = r_pidx;
            end
        endcase
    end

    assign fin_value = (r_op == OP_COUNT || r_op == OP_CARD || r_op == OP_DISTINCT)
                       ? r_acc : '0;
    always_comb begin
        unique case (r_op)
            OP_COUNT, OP_SUBSET, OP_EQUAL, OP_EMPTY: fin_flag = r_flag;
            OP_CARD, OP_DISTINCT:                    fin_flag = r_acc != '0;
            default:                                 fin_flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_WALK);
            if (r_state == S_INIT || r_state == S_WALK) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + AW'(1);
            end
            if (r_state == S_FINISH && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        if (s_fire) begin
            r_op   <= in_op;
            r_sel  <= i_s_tuser[4];
            r_el   <= i_s_tdata;
            r_acc  <= '0;
            r_flag <= 1'b1;
            r_sat  <= 1'b0;
        end else if (r_state == S_ELEM) begin
            r_acc  <= (r_op == OP_COUNT && r_in_range) ? t32[VALUE_W-1:0] : '0;
            r_flag <= r_in_range && cur_t != '0;
            r_sat  <= (r_op == OP_ADD) && r_in_range && cur_t == CNT_MAX;
        end else if (r_pv && is_walk_op) begin
            r_acc <= acc_next;
            if (walk_bad) begin
                r_flag <= 1'b0;
            end
            if (walk_sat) begin
                r_sat <= 1'b1;
            end
        end
        if (r_state == S_FINISH && out_free) begin
            r_odata <= {6'b0, r_sat, fin_flag, fin_value};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

// ----- rtl/core/mce_checker.sv -----
// Port-level checker for the multiset count engine, bound to the top level.
// Depends on multiset_count_engine.
`timescale 1ns / 1ps

module mce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second request taken while one is in flight");

    a_sat_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[25] |-> o_m_tdata[23:0] == 24'd0 && o_m_tdata[31:26] == 6'd0)
        else $error("saturated result carries a value");

    a_value_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[23:0] != 24'd0 |-> o_m_tdata[24])
        else $error("nonzero value without flag");

endmodule

bind multiset_count_engine mce_checker u_mce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the multiset count engine: directed requests, then random mixes.
// A scoreboard class keeps its own copy of both bags and predicts every result in order.
// Depends on mce_pkg and multiset_count_engine.
`timescale 1ns / 1ps

import mce_pkg::*;

typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               flag;
    logic               saturated;
} t_bag_result;

class bag_scoreboard;
    localparam logic [COUNT_WIDTH_DEF-1:0] CNT_MAX = {COUNT_WIDTH_DEF{1'b1}};

    logic [COUNT_WIDTH_DEF-1:0] counts [2][DIM_DEF];
    t_bag_result                expected_q [$];
    int                         err_count;

    function new();
        foreach (counts[b, i]) counts[b][i] = '0;
        err_count = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
        err_count++;
        $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    function void note_request(logic [3:0] req, logic sel, logic [7:0] elem);
        t_bag_result               res;
        logic                      tb_sel;
        logic                      ob_sel;
        logic [COUNT_WIDTH_DEF:0]  sum;
        int unsigned               acc;
        int                        i;
        res    = '0;
        tb_sel = sel;
        ob_sel = ~sel;
        acc    = 0;
        case (req)
            OP_ADD: begin
                if (counts[tb_sel][elem] == CNT_MAX) res.saturated = 1'b1;
                else counts[tb_sel][elem] = counts[tb_sel][elem] + COUNT_WIDTH_DEF'(1);
            end
            OP_REMOVE: begin
                if (counts[tb_sel][elem] != '0) begin
                    counts[tb_sel][elem] = counts[tb_sel][elem] - COUNT_WIDTH_DEF'(1);
                end
            end
            OP_COUNT: begin
                res.value = VALUE_W'(counts[tb_sel][elem]);
                res.flag  = (counts[tb_sel][elem] != '0);
            end
            OP_CLEAR: begin
                for (i = 0; i < DIM_DEF; i++) counts[tb_sel][i] = '0;
            end
            OP_COPY: begin
                for (i = 0; i < DIM_DEF; i++) counts[tb_sel][i] = counts[ob_sel][i];
            end
            OP_UNION: begin
                for (i = 0; i < DIM_DEF; i++) begin
                    sum = {1'b0, counts[tb_sel][i]} + {1'b0, counts[ob_sel][i]};
                    if (sum > {1'b0, CNT_MAX}) begin
                        sum = {1'b0, CNT_MAX};
                        res.saturated = 1'b1;
                    end
                    counts[tb_sel][i] = sum[COUNT_WIDTH_DEF-1:0];
                end
            end
            OP_INTERSECT: begin
                for (i = 0; i < DIM_DEF; i++) begin
                    if (counts[tb_sel][i] > counts[ob_sel][i]) begin
                        counts[tb_sel][i] = counts[ob_sel][i];
                    end
                end
            end
            OP_DIFF: begin
                for (i = 0; i < DIM_DEF; i++) begin
                    if (counts[tb_sel][i] < counts[ob_sel][i]) counts[tb_sel][i] = '0;
                    else counts[tb_sel][i] = counts[tb_sel][i] - counts[ob_sel][i];
                end
            end
            OP_SUBSET: begin
                res.flag = 1'b1;
                for (i = 0; i < DIM_DEF; i++) begin
                    if (counts[tb_sel][i] > counts[ob_sel][i]) res.flag = 1'b0;
                end
            end
            OP_EQUAL: begin
                res.flag = 1'b1;
                for (i = 0; i < DIM_DEF; i++) begin
                    if (counts[tb_sel][i] != counts[ob_sel][i]) res.flag = 1'b0;
                end
            end
            OP_EMPTY: begin
                res.flag = 1'b1;
                for (i = 0; i < DIM_DEF; i++) begin
                    if (counts[tb_sel][i] != '0) res.flag = 1'b0;
                end
            end
            OP_CARD, OP_DISTINCT: begin
                for (i = 0; i < DIM_DEF; i++) begin
                    if (req == OP_CARD) acc += counts[tb_sel][i];
                    else if (counts[tb_sel][i] != '0) acc++;
                end
                res.value = (acc > VALUE_MAX) ? VALUE_MAX : acc[VALUE_W-1:0];
                res.flag  = (acc != 0);
            end
            default: begin
            end
        endcase
        expected_q.push_back(res);
    endfunction

    task check_result(logic [31:0] tdata);
        t_bag_result want;
        if (expected_q.size() == 0) begin
            report("unexpected result", '0, tdata);
        end else begin
            want = expected_q.pop_front();
            if (tdata[23:0] != want.value) begin
                report("value", 32'(want.value), 32'(tdata[23:0]));
            end
            if (tdata[24] != want.flag) begin
                report("flag", 32'(want.flag), 32'(tdata[24]));
            end
            if (tdata[25] != want.saturated) begin
                report("saturated", 32'(want.saturated), 32'(tdata[25]));
            end
        end
    endtask
endclass

module tb;
    localparam int RANDOM_ITEMS = 1500;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;    // [7:0] element
    logic [4:0]  i_s_tuser  = '0;    // [3:0] req_type, [4] bag_sel
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;          // [23:0] value, [24] flag, [25] saturated

    bag_scoreboard sb = new();
    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int items_sent    = 0;

    multiset_count_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.note_request(i_s_tuser[3:0], i_s_tuser[4], i_s_tdata);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
        i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    task automatic send_request(input logic [3:0] req, input logic sel, input logic [7:0] elem);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= {sel, req};
        i_s_tdata  <= elem;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_element();
        return ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    initial begin
        int          phase;
        int          stop_at;
        int          n;
        int          k;
        int unsigned kind;
        logic        s;
        logic [7:0]  e;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_ADD, 1'b0, 8'd0);
        send_request(OP_ADD, 1'b0, 8'd0);
        send_request(OP_ADD, 1'b0, 8'd255);
        send_request(OP_ADD, 1'b1, 8'd255);
        send_request(OP_COUNT, 1'b0, 8'd0);
        send_request(OP_COUNT, 1'b1, 8'd0);
        send_request(OP_REMOVE, 1'b1, 8'd0);
        send_request(OP_REMOVE, 1'b0, 8'd0);
        send_request(OP_SUBSET, 1'b1, 8'hAA);
        send_request(OP_SUBSET, 1'b0, 8'h55);
        send_request(OP_EQUAL, 1'b0, 8'd0);
        send_request(OP_COPY, 1'b1, 8'd0);
        send_request(OP_EQUAL, 1'b1, 8'd0);
        send_request(OP_UNION, 1'b0, 8'd0);
        send_request(OP_INTERSECT, 1'b1, 8'd0);
        send_request(OP_DIFF, 1'b1, 8'd0);
        send_request(OP_EMPTY, 1'b1, 8'd0);
        send_request(OP_EMPTY, 1'b0, 8'd0);
        send_request(OP_CARD, 1'b0, 8'd0);
        send_request(OP_DISTINCT, 1'b0, 8'd0);
        send_request(OP_CLEAR, 1'b0, 8'd0);
        send_request(OP_CARD, 1'b0, 8'd0);
        send_request(4'd13, 1'b0, 8'd255);
        send_request(4'd14, 1'b1, 8'd1);
        send_request(4'd15, 1'b1, 8'd128);
        wait_idle();

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 62 : 0;
            rcv_idle_pct  = (phase == 0) ? 62 : (phase == 1) ? 30 : 0;
            stop_at = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < stop_at) begin
                kind = $urandom_range(99);
                s    = 1'($urandom_range(1));
                if (kind < 55) begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        k = $urandom_range(3);
                        send_request((k < 2) ? OP_ADD : (k == 2) ? OP_REMOVE : OP_COUNT,
                                     1'($urandom_range(1)), pick_element());
                    end
                end else if (kind < 80) begin
                    send_request(4'($urandom_range(15)), s, 8'($urandom_range(255)));
                end else if (kind < 95) begin
                    send_request(OP_COPY, s, 8'($urandom_range(255)));
                    n = $urandom_range(0, 4);
                    repeat (n) begin
                        send_request(($urandom_range(1) != 0) ? OP_ADD : OP_REMOVE,
                                     1'($urandom_range(1)), pick_element());
                    end
                    send_request(4'($urandom_range(OP_INTERSECT, OP_DISTINCT)),
                                 1'($urandom_range(1)), 8'($urandom_range(255)));
                end else begin
                    // Doubling by copy and union drives counts up to the clamp quickly.
                    e = pick_element();
                    send_request(OP_ADD, s, e);
                    k = $urandom_range(1, 17);
                    repeat (k) begin
                        send_request(OP_COPY, ~s, 8'($urandom_range(255)));
                        send_request(OP_UNION, s, 8'($urandom_range(255)));
                    end
                    send_request(OP_ADD, s, e);
                    send_request(OP_COUNT, s, e);
                    send_request(OP_CARD, s, 8'($urandom_range(255)));
                    if ($urandom_range(1) != 0) begin
                        send_request(OP_CLEAR, 1'b0, 8'($urandom_range(255)));
                        send_request(OP_CLEAR, 1'b1, 8'($urandom_range(255)));
                    end
                end
            end
            wait_idle();
        end

        repeat (DIM_DEF + 16) @(posedge i_clk);
        if (sb.err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
